@@ design/ugcb_pkg.sv @@
// ----------------------------------------------------------------------------
// ugcb_pkg
// Shared types and constants for the uniform grid cell binning block.
// ----------------------------------------------------------------------------
package ugcb_pkg;

  localparam int unsigned DimMax      = 32;
  localparam int unsigned MaxBuckets  = 1024;
  localparam int unsigned BucketSlots = 16;
  localparam int unsigned MaxWallIds  = 4096;

  localparam int unsigned MapDepth = DimMax * DimMax * DimMax;
  localparam int unsigned CellW    = $clog2(MapDepth);
  localparam int unsigned BktW     = $clog2(MaxBuckets);
  localparam int unsigned SlotW    = $clog2(BucketSlots);
  localparam int unsigned FillW    = $clog2(BucketSlots + 1);
  localparam int unsigned UsedW    = $clog2(MaxBuckets + 1);
  localparam int unsigned WallW    = $clog2(MaxWallIds);
  localparam int unsigned WcntW    = $clog2(MaxWallIds + 1);
  localparam int unsigned CoordW   = $clog2(DimMax);
  localparam int unsigned DimW     = $clog2(DimMax + 1);

  localparam int unsigned NumCfg = 7;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinX = 3'd0, RegMinY = 3'd1, RegMinZ = 3'd2,
    RegMaxX = 3'd3, RegMaxY = 3'd4, RegMaxZ = 3'd5,
    RegInvCell = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StCleared   = 2'd1,
    StBktFull   = 2'd2,
    StNoBucket  = 2'd3
  } status_e;

  typedef struct packed {
    logic        action;
    logic [15:0] item_id;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] cell_index;
    logic [9:0]  bucket_index;
    logic [3:0]  slot;
    logic        new_bucket;
    logic        near_wall;
    logic        wall_list_full;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;    // empty one map entry after reset
    logic load;       // capture input item
    logic axis_step;  // run one axis of the cell computation
    logic [1:0] axis;
    logic lin_step;   // linear index step
    logic map_rd;     // issue map read
    logic fill_rd;    // issue fill read
    logic commit;     // write back insert
    logic clr_rd;     // read next touched cell
    logic clr_wr;     // invalidate map entry
    logic clr_done;   // reset pool and wall list
    logic out_load;   // form result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;  // last map entry of the reset pass
    logic is_clear;
    logic clr_more;   // touched cells left to walk
  } dp_sts_t;

endpackage

@@ design/ugcb_stream_if.sv @@
// ----------------------------------------------------------------------------
// ugcb_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ugcb_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/uniform_grid_cell_binning.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_cell_binning
// Bins particles into a uniform 3D grid of compact buckets.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_if    in   action, item_id, pos_x/y/z, radius
// out_if   out  status, cell_index, bucket_index, slot, flags
// cfg      in   we, idx[2:0], data[31:0]
// Insert: decode, one axis per cycle, two index steps, map and fill memory
//   reads, then commit; the next item is accepted after the commit.
// Clear: walks the touched-cell list, invalidating each touched map entry.
// Reset clears pool and wall counts at once, then a pass over all 32768
//   map entries empties the map while the input is held off.
// Output is registered; a stalled result holds the commit or clear-done step.
// ----------------------------------------------------------------------------
module uniform_grid_cell_binning (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ugcb_stream_if.sink   in_if,
  ugcb_stream_if.source out_if
);
  import ugcb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_valid;

  ugcb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ugcb_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(in_if.data), .cmd_i(cmd), .sts_o(sts), .res_o(out_if.data)
  );

  assign out_if.valid = out_valid;
endmodule

@@ design/ugcb_datapath.sv @@
// ----------------------------------------------------------------------------
// ugcb_datapath
// Cell index arithmetic, map/bucket/wall memories and result formation.
// ----------------------------------------------------------------------------
module ugcb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  ugcb_pkg::in_item_t  item_i,
  input  ugcb_pkg::dp_cmd_t   cmd_i,
  output ugcb_pkg::dp_sts_t   sts_o,
  output ugcb_pkg::out_item_t res_o
);
  import ugcb_pkg::*;

  logic [31:0] cfg_q [NumCfg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[RegMinX] <= '0; cfg_q[RegMinY] <= '0; cfg_q[RegMinZ] <= '0;
      cfg_q[RegMaxX] <= 32'd2097152; cfg_q[RegMaxY] <= 32'd2097152;
      cfg_q[RegMaxZ] <= 32'd2097152; cfg_q[RegInvCell] <= 32'd65536;
    end else if (cfg_we_i && (cfg_idx_i < 3'(NumCfg))) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic [31:0] inv;
  assign inv = (cfg_q[RegInvCell] == '0) ? 32'd65536 : cfg_q[RegInvCell];

  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  // one axis per step: two 32x32 products; the clamped cell and dimension are registered
  logic signed [32:0] pos_a, min_a, max_a, rel, ext;
  logic signed [33:0] lo_t, hi_t;
  logic [64:0] prel, pext;
  logic [CoordW-1:0] coord_q [3];
  logic [DimW-1:0]   dim_q   [3];
  logic              near_q;
  logic [DimW-1:0]   dim_n;
  logic [CoordW-1:0] coord_n;
  logic [32:0]       qd, qc;

  always_comb begin
    unique case (cmd_i.axis)
      2'd0:    pos_a = 33'(signed'(item_q.pos_x));
      2'd1:    pos_a = 33'(signed'(item_q.pos_y));
      default: pos_a = 33'(signed'(item_q.pos_z));
    endcase
    min_a = 33'(signed'(cfg_q[{1'b0, cmd_i.axis}]));
    max_a = 33'(signed'(cfg_q[3'(cmd_i.axis) + 3'd3]));
    rel   = pos_a - min_a;
    ext   = max_a - min_a;
    lo_t  = 34'(pos_a) - 34'(signed'({2'b0, item_q.radius}));
    hi_t  = 34'(pos_a) + 34'(signed'({2'b0, item_q.radius}));
    prel  = 65'(rel[31:0]) * 65'(inv);
    pext  = 65'(ext[31:0]) * 65'(inv);
    qd    = pext[64:32] + 33'(pext[31:0] != '0);
    if (ext <= 0)                  dim_n = DimW'(1);
    else if (qd > 33'(DimMax))     dim_n = DimW'(DimMax);
    else if (qd == '0)             dim_n = DimW'(1);
    else                           dim_n = qd[DimW-1:0];
    qc = prel[64:32];
    if (rel < 0)                      coord_n = '0;
    else if (qc >= 33'(dim_n))        coord_n = CoordW'(dim_n - DimW'(1));
    else                              coord_n = qc[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) near_q <= 1'b0;
    if (cmd_i.axis_step) begin
      coord_q[cmd_i.axis] <= coord_n;
      dim_q[cmd_i.axis]   <= dim_n;
      if (lo_t <= 34'(min_a) || hi_t >= 34'(max_a)) near_q <= 1'b1;
    end
  end

  // linear index: two small multiply steps
  logic [CellW-1:0] lid_q;
  logic             lin_ph_q;
  logic [2*DimW+CoordW:0] acc;
  always_comb begin
    if (!lin_ph_q) begin
      acc = ($bits(acc))'(coord_q[1]) +
            ($bits(acc))'(dim_q[1]) * ($bits(acc))'(coord_q[2]);
    end else begin
      acc = ($bits(acc))'(coord_q[0]) +
            ($bits(acc))'(dim_q[0]) * ($bits(acc))'(lid_q);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lin_ph_q <= 1'b0;
    else if (cmd_i.load) lin_ph_q <= 1'b0;
    else if (cmd_i.lin_step) lin_ph_q <= ~lin_ph_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_step) lid_q <= acc[CellW-1:0];
  end

  // map entries hold a valid bit over the bucket number; a pass after reset
  // empties every entry, and a clear invalidates only the touched cells
  logic [BktW:0]       map_mem [MapDepth];
  logic [BktW:0]       map_rd_q;
  logic                map_hit;
  logic [CellW-1:0]    init_q;
  logic [CellW-1:0]    touched_mem [MaxBuckets];
  logic [CellW-1:0]    tc_rd_q;
  logic [FillW-1:0]    fill_mem [MaxBuckets];
  logic [FillW-1:0]    fill_rd_q;
  logic [15:0]         memb_mem [MaxBuckets*BucketSlots];
  logic [15:0]         wall_mem [MaxWallIds];
  logic [UsedW-1:0]    used_q, walk_q;
  logic [WcntW-1:0]    wcnt_q;

  assign map_hit = map_rd_q[BktW];

  logic no_bkt, bkt_full, do_ins, do_wall, wfull;
  logic [BktW-1:0] bkt;
  assign no_bkt   = !map_hit && (used_q >= UsedW'(MaxBuckets));
  assign bkt      = map_hit ? map_rd_q[BktW-1:0] : used_q[BktW-1:0];
  assign bkt_full = !no_bkt && map_hit && (fill_rd_q >= FillW'(BucketSlots));
  assign do_ins   = !no_bkt && !bkt_full;
  assign do_wall  = do_ins && near_q && (wcnt_q < WcntW'(MaxWallIds));
  assign wfull    = do_ins && near_q && (wcnt_q >= WcntW'(MaxWallIds));

  logic [FillW-1:0] cur_fill;
  assign cur_fill = map_hit ? fill_rd_q : '0;

  // single map write port shared by the reset pass, clear and insert
  logic             map_we;
  logic [CellW-1:0] map_wa;
  logic [BktW:0]    map_wd;
  always_comb begin
    map_we = 1'b0;
    map_wa = lid_q;
    map_wd = '0;
    if (cmd_i.init_wr) begin
      map_we = 1'b1;
      map_wa = init_q;
    end else if (cmd_i.clr_wr) begin
      map_we = 1'b1;
      map_wa = tc_rd_q;
    end else if (cmd_i.commit && do_ins && !map_hit) begin
      map_we = 1'b1;
      map_wd = {1'b1, bkt};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_rd) map_rd_q <= map_mem[lid_q];
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.fill_rd) fill_rd_q <= fill_mem[map_rd_q[BktW-1:0]];
    if (cmd_i.commit && do_ins) begin
      fill_mem[bkt] <= cur_fill + FillW'(1);
      memb_mem[{bkt, cur_fill[SlotW-1:0]}] <= item_q.item_id;
      if (!map_hit) touched_mem[bkt] <= lid_q;
    end
    if (cmd_i.commit && do_wall) wall_mem[wcnt_q[WallW-1:0]] <= item_q.item_id;
    if (cmd_i.clr_rd) tc_rd_q <= touched_mem[walk_q[BktW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0; wcnt_q <= '0; walk_q <= '0; init_q <= '0;
    end else begin
      if (cmd_i.init_wr) init_q <= init_q + CellW'(1);
      if (cmd_i.commit && do_ins && !map_hit) used_q <= used_q + UsedW'(1);
      if (cmd_i.commit && do_wall) wcnt_q <= wcnt_q + WcntW'(1);
      if (cmd_i.load) walk_q <= '0;
      if (cmd_i.clr_rd) walk_q <= walk_q + UsedW'(1);
      if (cmd_i.clr_done) begin
        used_q <= '0; wcnt_q <= '0;
      end
    end
  end

  assign sts_o.init_last = (init_q == CellW'(MapDepth - 1));
  assign sts_o.is_clear  = item_q.action;
  assign sts_o.clr_more  = walk_q < used_q;

  out_item_t res_d, res_q;
  always_comb begin
    res_d = '0;
    if (item_q.action) begin
      res_d.status = StCleared;
    end else begin
      res_d.cell_index = 15'(lid_q);
      res_d.near_wall  = near_q;
      if (no_bkt) begin
        res_d.status = StNoBucket;
      end else if (bkt_full) begin
        res_d.status = StBktFull;
        res_d.bucket_index = 10'(bkt);
      end else begin
        res_d.status = StInserted;
        res_d.bucket_index = 10'(bkt);
        res_d.slot = 4'(cur_fill[SlotW-1:0]);
        res_d.new_bucket = !map_hit;
        res_d.wall_list_full = wfull;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) res_q <= res_d;
  end
  assign res_o = res_q;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(MaxBuckets)) else $error("bucket pool overrun");
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WcntW'(MaxWallIds)) else $error("wall list overrun");
  a_clr_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_done |=> used_q == '0 && wcnt_q == '0) else $error("clear left state");
`endif
endmodule

@@ design/ugcb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ugcb_ctrl
// Sequencer for insert and clear items.
// ----------------------------------------------------------------------------
module ugcb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ugcb_pkg::dp_sts_t sts_i,
  output ugcb_pkg::dp_cmd_t cmd_o
);
  import ugcb_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AX0, S_AX1, S_AX2, S_LIN0, S_LIN1, S_MAP, S_FILL, S_COMMIT,
    S_CRD, S_CWR, S_CDONE, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_INIT: cmd_o.init_wr = 1'b1;
      S_AX0:  begin cmd_o.axis_step = 1'b1; cmd_o.axis = 2'd0; end
      S_AX1:  begin cmd_o.axis_step = 1'b1; cmd_o.axis = 2'd1; end
      S_AX2:  begin cmd_o.axis_step = 1'b1; cmd_o.axis = 2'd2; end
      S_LIN0, S_LIN1: cmd_o.lin_step = 1'b1;
      S_MAP:  cmd_o.map_rd = 1'b1;
      S_FILL: cmd_o.fill_rd = 1'b1;
      S_COMMIT: if (out_free) begin cmd_o.commit = 1'b1; cmd_o.out_load = 1'b1; end
      S_CRD:  if (sts_i.clr_more) cmd_o.clr_rd = 1'b1;
      S_CWR:  cmd_o.clr_wr = 1'b1;
      S_CDONE: if (out_free) begin cmd_o.clr_done = 1'b1; cmd_o.out_load = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT:  if (sts_i.init_last) state_q <= S_IDLE;
        S_IDLE:  if (in_valid_i) state_q <= S_OUT;
        S_OUT:   state_q <= sts_i.is_clear ? S_CRD : S_AX0;
        S_AX0:   state_q <= S_AX1;
        S_AX1:   state_q <= S_AX2;
        S_AX2:   state_q <= S_LIN0;
        S_LIN0:  state_q <= S_LIN1;
        S_LIN1:  state_q <= S_MAP;
        S_MAP:   state_q <= S_FILL;
        S_FILL:  state_q <= S_COMMIT;
        S_COMMIT: if (out_free) state_q <= S_IDLE;
        S_CRD:   state_q <= sts_i.clr_more ? S_CWR : S_CDONE;
        S_CWR:   state_q <= S_CRD;
        S_CDONE: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.commit, cmd_o.clr_rd, cmd_o.clr_wr, cmd_o.map_rd, cmd_o.init_wr}))
    else $error("overlapping commands");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free) else $error("result overwritten");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o) else $error("accepted while busy");
`endif
endmodule

@@ tb/tb_uniform_grid_cell_binning.sv @@
// ----------------------------------------------------------------------------
// tb_uniform_grid_cell_binning
// Self-checking bench for the grid binning block: a queue-fed driver, a
// stalling monitor and an in-bench grid predictor over several box settings.
// ----------------------------------------------------------------------------
module tb_uniform_grid_cell_binning;
  timeunit 1ns;
  timeprecision 1ps;
  import ugcb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  ugcb_stream_if #(.payload_t(in_item_t)) in_if ();
  ugcb_stream_if #(.payload_t(out_item_t)) out_if ();

  uniform_grid_cell_binning dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // the map pass after reset alone visits all 32768 map entries
  localparam int unsigned WatchLimit = 150000;

  // predictor state
  logic [31:0] grid_reg [NumCfg];
  logic        map_valid [MapDepth];
  logic [9:0]  map_bucket [MapDepth];
  logic [14:0] touched [MaxBuckets];
  int unsigned fill [MaxBuckets];
  int unsigned buckets_used, wall_count;

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic add_item(input in_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic longint unsigned inv_cell();
    return (grid_reg[RegInvCell] == 0) ? 64'd65536 : {32'd0, grid_reg[RegInvCell]};
  endfunction

  function automatic int unsigned axis_dim(input int a);
    longint ext;
    longint unsigned p, q;
    ext = longint'($signed(grid_reg[3+a])) - longint'($signed(grid_reg[a]));
    if (ext <= 0) return 1;
    p = longint'(ext) * inv_cell();
    q = p >> 32;
    if (p[31:0] != 0) q++;
    if (q < 1) q = 1;
    if (q > DimMax) q = DimMax;
    return 32'(q);
  endfunction

  function automatic int unsigned axis_cell(input int a, input longint pos,
                                            input int unsigned dim);
    longint rel;
    longint unsigned q;
    rel = pos - longint'($signed(grid_reg[a]));
    if (rel < 0) return 0;
    q = (longint'(rel) * inv_cell()) >> 32;
    if (q >= dim) q = dim - 1;
    return 32'(q);
  endfunction

  function automatic out_item_t bin_particle(input in_item_t it);
    out_item_t r;
    int unsigned dim [3], c [3], lid, b;
    longint pos [3], rad;
    r = '0;
    if (it.action) begin
      for (int i = 0; i < buckets_used; i++) map_valid[touched[i]] = 1'b0;
      buckets_used = 0;
      wall_count = 0;
      r.status = StCleared;
      return r;
    end
    pos[0] = longint'($signed(it.pos_x));
    pos[1] = longint'($signed(it.pos_y));
    pos[2] = longint'($signed(it.pos_z));
    rad = longint'({33'd0, it.radius});
    for (int a = 0; a < 3; a++) begin
      dim[a] = axis_dim(a);
      c[a] = axis_cell(a, pos[a], dim[a]);
      if (pos[a] - rad <= longint'($signed(grid_reg[a])) ||
          pos[a] + rad >= longint'($signed(grid_reg[3+a]))) r.near_wall = 1'b1;
    end
    lid = (c[0] + dim[0] * (c[1] + dim[1] * c[2])) % MapDepth;
    r.cell_index = 15'(lid);
    r.status = StInserted;
    b = 0;
    if (!map_valid[lid]) begin
      if (buckets_used >= MaxBuckets) begin
        r.status = StNoBucket;
        return r;
      end
      b = buckets_used++;
      fill[b] = 0;
      touched[b] = 15'(lid);
      map_valid[lid] = 1'b1;
      map_bucket[lid] = 10'(b);
      r.new_bucket = 1'b1;
    end else begin
      b = map_bucket[lid];
    end
    r.bucket_index = 10'(b);
    if (fill[b] >= BucketSlots) begin
      r.status = StBktFull;
      return r;
    end
    r.slot = 4'(fill[b]);
    fill[b]++;
    if (r.near_wall) begin
      if (wall_count < MaxWallIds) wall_count++;
      else r.wall_list_full = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // driver: predict on acceptance
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results = {expected_results, bin_particle(in_if.data)};
        src_gap = gap_len();
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_items.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor with random back-pressure
  int unsigned sink_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          out_item_t e, g;
          e = expected_results.pop_front();
          g = out_if.data;
          if (g.status != e.status)
            report_mismatch($sformatf("status %0d exp %0d", g.status, e.status));
          if (g.cell_index != e.cell_index)
            report_mismatch($sformatf("cell %0d exp %0d", g.cell_index, e.cell_index));
          if (g.bucket_index != e.bucket_index)
            report_mismatch($sformatf("bucket %0d exp %0d", g.bucket_index,
                                      e.bucket_index));
          if (g.slot != e.slot)
            report_mismatch($sformatf("slot %0d exp %0d", g.slot, e.slot));
          if (g.new_bucket != e.new_bucket)
            report_mismatch($sformatf("new_bucket %0d exp %0d", g.new_bucket,
                                      e.new_bucket));
          if (g.near_wall != e.near_wall)
            report_mismatch($sformatf("near_wall %0d exp %0d", g.near_wall,
                                      e.near_wall));
          if (g.wall_list_full != e.wall_list_full)
            report_mismatch($sformatf("wall_full %0d exp %0d", g.wall_list_full,
                                      e.wall_list_full));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        sink_gap = gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (pending_items.size() == 0 && expected_results.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_reg[idx] = val;
  endtask

  task automatic drain();
    // sample between edges so queue and handshake updates have settled
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_if.valid)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_insert(input logic [15:0] id, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [30:0] r);
    in_item_t it;
    it.action = 1'b0;
    it.item_id = id;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.radius = r;
    return it;
  endfunction

  function automatic in_item_t mk_clear();
    in_item_t it;
    it = '0;
    it.action = 1'b1;
    it.item_id = 16'($urandom());
    it.pos_x = $urandom();
    it.pos_y = $urandom();
    it.pos_z = $urandom();
    it.radius = 31'($urandom());
    return it;
  endfunction

  // position near the box along one axis, sometimes well outside
  function automatic logic [31:0] near_box(input int a);
    longint lo, hi, v;
    lo = longint'($signed(grid_reg[a]));
    hi = longint'($signed(grid_reg[3+a]));
    if ($urandom_range(0, 9) == 0) return $urandom();
    if (hi <= lo) hi = lo + 65536;
    v = lo - 65536 + longint'($urandom_range(0, 1 << 30) % (hi - lo + 131072));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'($urandom_range(0, 65536));
      2: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic random_phase(input int n, input int unsigned id_span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) add_item(mk_clear());
      else add_item(mk_insert(16'($urandom_range(0, id_span)), near_box(0),
                              near_box(1), near_box(2), rand_radius()));
    end
    drain();
  endtask

  task automatic set_box(input logic [31:0] mn, input logic [31:0] mx,
                         input logic [31:0] inv);
    write_reg(RegMinX, mn);
    write_reg(RegMinY, mn);
    write_reg(RegMinZ, mn);
    write_reg(RegMaxX, mx);
    write_reg(RegMaxY, mx);
    write_reg(RegMaxZ, mx);
    write_reg(RegInvCell, inv);
    add_item(mk_clear());
    drain();
  endtask

  initial begin
    grid_reg[RegMinX] = 0; grid_reg[RegMinY] = 0; grid_reg[RegMinZ] = 0;
    grid_reg[RegMaxX] = 32'd2097152; grid_reg[RegMaxY] = 32'd2097152;
    grid_reg[RegMaxZ] = 32'd2097152; grid_reg[RegInvCell] = 32'd65536;
    for (int i = 0; i < MapDepth; i++) map_valid[i] = 1'b0;
    buckets_used = 0;
    wall_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, clamps, wall touch, bucket overflow, clear
    add_item(mk_insert(16'h0000, 32'h0000_0000, 0, 0, 31'd0));
    add_item(mk_insert(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 31'h7FFF_FFFF));
    add_item(mk_insert(16'h1234, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 31'd0));
    add_item(mk_insert(16'h0055, 32'h0010_8000, 32'h0010_8000,
                       32'h0010_8000, 31'h0000_8000));
    add_item(mk_insert(16'h00AA, 32'h001F_FFFF, 32'h0000_0001,
                       32'h0010_0000, 31'd0));
    for (int i = 0; i < 18; i++)
      add_item(mk_insert(16'(i), 32'h0005_0000, 32'h0006_0000,
                         32'h0007_0000, 31'd1));
    add_item(mk_clear());
    drain();

    random_phase(100, 16'hFFFF);
    // few cells, coarse grid: stresses bucket overflow
    set_box(32'h0000_0000, 32'h0004_0000, 32'h0000_8000);
    random_phase(100, 16'hFFFF);
    // zero reciprocal and inverted box
    set_box(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000);
    random_phase(50, 16'hFFFF);
    // extreme box spread over all 32K cells: pool exhaustion
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0020);
    for (int i = 0; i < 1100; i++)
      add_item(mk_insert(16'($urandom()), $urandom(), $urandom(), $urandom(),
                         rand_radius()));
    add_item(mk_clear());
    drain();
    // huge reciprocal on the same box: almost everything clamps to the far corner
    write_reg(RegInvCell, 32'hFFFF_FFFF);
    add_item(mk_clear());
    drain();
    random_phase(30, 16'hFFFF);
    // tiny reciprocal, mixed box
    write_reg(RegMinX, 32'hFFFF_0000);
    write_reg(RegMaxY, 32'h0100_0000);
    write_reg(RegInvCell, 32'd1);
    add_item(mk_clear());
    drain();
    random_phase(30, 16'hFFFF);
    set_box(32'h0000_0000, 32'h0020_0000, 32'h0001_0000);
    random_phase(100, 16'hFFFF);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ugcb_pkg.sv
design/ugcb_stream_if.sv
design/ugcb_datapath.sv
design/ugcb_ctrl.sv
design/uniform_grid_cell_binning.sv
tb/tb_uniform_grid_cell_binning.sv
